// ----- hdl/sapi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sapi_pkg;

  localparam int TABLE_POINTS_DEF    = 38;
  localparam int ANGLE_FRAC_BITS_DEF = 4;
  localparam int ANGLE_W             = 12;
  localparam int PWM_W               = 16;
  localparam int IDX_FIELD_W         = 6;
  localparam int LIMIT_W             = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd576;
  localparam int BUILTIN_POINTS      = 38;
  localparam int JOB_FIFO_DEPTH      = 2;
  localparam int RES_FIFO_DEPTH      = 2;
  localparam int DIV_STEPS           = PWM_W;
  localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

  localparam logic FUNC_WRITE = 1'b1;

  // built-in calibration points, angle in half degrees
  localparam logic signed [7:0] BUILTIN_HALF_DEG [BUILTIN_POINTS] = '{
    -72, -64, -58, -52, -48, -44, -40, -36, -28, -26, -20, -14, -12, -8, -4, -2,
    0, 2, 3, 6, 9, 14, 17, 20, 24, 26, 28, 30, 32, 34, 40, 42, 44, 46, 48, 50,
    51, 72
  };
  localparam logic [PWM_W-1:0] BUILTIN_PWM [BUILTIN_POINTS] = '{
    3400, 3410, 3420, 3500, 3600, 3750, 3800, 3900, 4000, 4100, 4200, 4300,
    4400, 4500, 4600, 4700, 4800, 4900, 5000, 5100, 5200, 5300, 5400, 5500,
    5600, 5700, 5800, 5900, 6000, 6100, 6200, 6300, 6400, 6500, 6600, 6700,
    6700, 7350
  };

  typedef struct packed {
    logic                      func;
    logic signed [ANGLE_W-1:0] angle;
    logic [IDX_FIELD_W-1:0]    point_index;
    logic [PWM_W-1:0]          point_pwm;
  } sapi_in_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm_value;
    logic             was_clamped;
  } sapi_out_t;

  typedef enum logic {
    JOB_CONVERT,
    JOB_WRITE
  } job_kind_t;

  typedef struct packed {
    job_kind_t                 kind;
    logic signed [ANGLE_W-1:0] angle;
    logic [IDX_FIELD_W-1:0]    point_index;
    logic [PWM_W-1:0]          point_pwm;
    logic                      clamped;
  } sapi_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIRST,
    BK_SCAN,
    BK_MUL,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } bk_state_t;

  function automatic logic signed [7:0] builtin_half(input logic [IDX_FIELD_W-1:0] idx);
    logic signed [7:0] r;
    r = '0;
    if (idx < BUILTIN_POINTS) begin
      r = BUILTIN_HALF_DEG[idx];
    end
    return r;
  endfunction

  function automatic logic [PWM_W-1:0] builtin_pwm(input logic [IDX_FIELD_W-1:0] idx);
    logic [PWM_W-1:0] r;
    r = '0;
    if (idx < BUILTIN_POINTS) begin
      r = BUILTIN_PWM[idx];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sapi_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sapi_fifo import sapi_pkg::*; #(
  parameter int DATA_W = PWM_W,
  parameter int DEPTH  = JOB_FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sapi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sapi_front import sapi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sapi_in_t           in_data,
  output logic               full,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               job_full,
  output logic               job_push,
  output sapi_job_t          job
);

  logic [LIMIT_W-1:0]      limit_r;
  logic signed [ANGLE_W:0] lim;
  logic signed [ANGLE_W:0] ang;
  logic                    is_write;
  logic                    below;
  logic                    above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  assign full     = job_full;
  assign job_push = push && !job_full;

  always_comb begin
    lim      = $signed({2'b00, limit_r});
    ang      = (ANGLE_W + 1)'(in_data.angle);
    is_write = (in_data.func == FUNC_WRITE);
    below    = (ang < -lim);
    above    = (ang > lim);

    job.kind        = is_write ? JOB_WRITE : JOB_CONVERT;
    job.point_index = in_data.point_index;
    job.point_pwm   = in_data.point_pwm;
    job.clamped     = !is_write && (below || above);
    if (is_write) begin
      job.angle = in_data.angle;
    end else if (below) begin
      job.angle = ANGLE_W'(-lim);
    end else if (above) begin
      job.angle = ANGLE_W'(lim);
    end else begin
      job.angle = in_data.angle;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sapi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sapi_back import sapi_pkg::*; #(
  parameter int TABLE_POINTS    = TABLE_POINTS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  input  sapi_job_t job,
  output logic      job_pop,
  input  logic      res_full,
  output sapi_out_t res,
  output logic      res_push
);

  localparam int ANG_W  = (ANGLE_FRAC_BITS + 8 > ANGLE_W) ? ANGLE_FRAC_BITS + 8 : ANGLE_W;
  localparam int IDX_W  = $clog2(TABLE_POINTS);
  localparam int ENT_W  = ANG_W + PWM_W;
  localparam int PROD_W = PWM_W + ANG_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_POINTS - 1);

  bk_state_t state_r;
  bk_state_t state_nxt;

  // calibration table
  logic [ENT_W-1:0]        mem [TABLE_POINTS];
  logic [TABLE_POINTS-1:0] valid_r;
  logic [ENT_W-1:0]        rdat_r;
  logic                    rvalid_r;
  logic [IDX_W-1:0]        raddr_r;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic                    wr_en;

  logic signed [7:0]       rst_half;
  logic signed [ANG_W-1:0] rst_ang;
  logic [PWM_W-1:0]        rst_pwm;
  logic signed [ANG_W-1:0] cur_ang;
  logic [PWM_W-1:0]        cur_pwm;

  logic signed [ANG_W-1:0] ang_r;
  logic                    clamped_r;
  logic signed [ANG_W-1:0] prev_ang_r;
  logic [PWM_W-1:0]        prev_pwm_r;
  logic signed [ANG_W-1:0] last_ang_r;
  logic [PWM_W-1:0]        last_pwm_r;
  logic [IDX_W-1:0]        scan_idx_r;
  logic [ANG_W-1:0]        span_r;
  logic [ANG_W-1:0]        dist_r;
  logic [PWM_W-1:0]        absd_r;
  logic                    neg_r;
  logic [PWM_W-1:0]        base_r;
  logic [ANG_W-1:0]        rem_r;
  logic [PWM_W-1:0]        lo_r;
  logic [DIV_CNT_W-1:0]    cnt_r;
  logic [PWM_W-1:0]        val_r;

  logic                    at_last;
  logic                    in_seg;
  logic                    scan_done;
  logic                    scan_mul;
  logic [PWM_W-1:0]        scan_val;
  logic signed [ANG_W:0]   span_full;
  logic signed [ANG_W:0]   dist_full;
  logic [PROD_W-1:0]       prod;
  logic [ANG_W:0]          trial;
  logic                    trial_ge;
  logic [ANG_W:0]          trial_sub;
  logic [PWM_W:0]          fin_sum;

  assign wr_addr = job.point_index[IDX_W-1:0];
  assign wr_en   = (state_r == BK_IDLE) && !job_empty && (job.kind == JOB_WRITE) &&
                   ({1'b0, job.point_index} < (IDX_FIELD_W + 1)'(TABLE_POINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {ANG_W'(job.angle), job.point_pwm};
    end
    rdat_r   <= mem[rd_addr];
    rvalid_r <= valid_r[rd_addr];
    raddr_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries read as the built-in point
  always_comb begin
    rst_half = builtin_half(IDX_FIELD_W'(raddr_r));
    rst_pwm  = builtin_pwm(IDX_FIELD_W'(raddr_r));
    rst_ang  = ANG_W'(rst_half) <<< (ANGLE_FRAC_BITS - 1);
    cur_ang  = rvalid_r ? rdat_r[ENT_W-1:PWM_W] : rst_ang;
    cur_pwm  = rvalid_r ? rdat_r[PWM_W-1:0] : rst_pwm;
  end

  // segment search
  always_comb begin
    at_last   = (scan_idx_r == LAST);
    in_seg    = (ang_r >= prev_ang_r) && (ang_r <= cur_ang);
    scan_done = 1'b0;
    scan_mul  = 1'b0;
    scan_val  = last_pwm_r;
    if (scan_idx_r == '0) begin
      if (ang_r <= cur_ang) begin
        scan_done = 1'b1;
        scan_val  = cur_pwm;
      end else if (ang_r >= last_ang_r) begin
        scan_done = 1'b1;
      end
    end else if (in_seg) begin
      if (cur_ang == prev_ang_r) begin
        scan_done = 1'b1;
        scan_val  = prev_pwm_r;
      end else begin
        scan_mul = 1'b1;
      end
    end else if (at_last) begin
      scan_done = 1'b1;
    end
    span_full = (ANG_W + 1)'(cur_ang) - (ANG_W + 1)'(prev_ang_r);
    dist_full = (ANG_W + 1)'(ang_r) - (ANG_W + 1)'(prev_ang_r);
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    prod      = PROD_W'(absd_r) * PROD_W'(dist_r);
    trial     = {rem_r, lo_r[PWM_W-1]};
    trial_ge  = (trial >= {1'b0, span_r});
    trial_sub = trial - {1'b0, span_r};
    if (neg_r) begin
      fin_sum = {1'b0, base_r} - {1'b0, lo_r} - (PWM_W + 1)'(rem_r != '0);
    end else begin
      fin_sum = {1'b0, base_r} + {1'b0, lo_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!job_empty && job.kind == JOB_CONVERT) begin
          state_nxt = BK_FIRST;
        end
      end
      BK_FIRST: state_nxt = BK_SCAN;
      BK_SCAN: begin
        if (scan_done) begin
          state_nxt = BK_DONE;
        end else if (scan_mul) begin
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: state_nxt = BK_DIV;
      BK_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = BK_FIN;
        end
      end
      BK_FIN: state_nxt = BK_DONE;
      BK_DONE: begin
        if (!res_full) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop         = 1'b0;
    res_push        = 1'b0;
    rd_addr         = '0;
    res.pwm_value   = (val_r == '0) ? last_pwm_r : val_r;
    res.was_clamped = clamped_r;
    case (state_r)
      BK_IDLE: begin
        job_pop = !job_empty;
        rd_addr = LAST;
      end
      BK_SCAN: rd_addr = at_last ? '0 : scan_idx_r + 1'b1;
      BK_DONE: res_push = !res_full;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        ang_r     <= ANG_W'(job.angle);
        clamped_r <= job.clamped;
      end
      BK_FIRST: begin
        last_ang_r <= cur_ang;
        last_pwm_r <= cur_pwm;
        scan_idx_r <= '0;
      end
      BK_SCAN: begin
        prev_ang_r <= cur_ang;
        prev_pwm_r <= cur_pwm;
        scan_idx_r <= scan_idx_r + 1'b1;
        val_r      <= scan_val;
        span_r     <= span_full[ANG_W-1:0];
        dist_r     <= dist_full[ANG_W-1:0];
        neg_r      <= (cur_pwm < prev_pwm_r);
        absd_r     <= (cur_pwm < prev_pwm_r) ? prev_pwm_r - cur_pwm : cur_pwm - prev_pwm_r;
        base_r     <= prev_pwm_r;
      end
      BK_MUL: begin
        rem_r <= prod[PROD_W-1:PWM_W];
        lo_r  <= prod[PWM_W-1:0];
        cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
      end
      BK_DIV: begin
        rem_r <= trial_ge ? trial_sub[ANG_W-1:0] : trial[ANG_W-1:0];
        lo_r  <= {lo_r[PWM_W-2:0], trial_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      BK_FIN: val_r <= fin_sum[PWM_W-1:0];
      default: val_r <= val_r;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/servo_angle_to_pwm_interpolator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake           Payload
// input     push / full         in_data   (sapi_in_t)
// result    empty / pop         out_data  (sapi_out_t)
// config    cfg_we              cfg_wdata (angle limit)
//
// A calibration write is done by the back end in its idle state. A convert
// passes FIRST, then one SCAN state per point until the search ends, then the
// multiply and 16-step divide when it lands inside a segment, and waits in DONE
// while the result queue is full; the table scan reads one point per cycle.
// Synchronous reset restores the angle limit and the built-in points at once.
// A two-beat queue sits between front and back and another on the result side.
module servo_angle_to_pwm_interpolator_unit import sapi_pkg::*; #(
  parameter int TABLE_POINTS    = TABLE_POINTS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sapi_in_t           in_data,
  output logic               empty,
  input  logic               pop,
  output sapi_out_t          out_data,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  sapi_job_t job_in;
  sapi_job_t job_out;
  logic      job_push;
  logic      job_full;
  logic      job_pop;
  logic      job_empty;
  sapi_out_t res;
  logic      res_push;
  logic      res_full;

  sapi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  sapi_fifo #(
    .DATA_W($bits(sapi_job_t)),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata(job_in),
    .full (job_full),
    .pop  (job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  sapi_back #(
    .TABLE_POINTS   (TABLE_POINTS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job      (job_out),
    .job_pop  (job_pop),
    .res_full (res_full),
    .res      (res),
    .res_push (res_push)
  );

  sapi_fifo #(
    .DATA_W($bits(sapi_out_t)),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(out_data),
    .empty(empty)
  );

endmodule
`default_nettype wire
